@@ design/vna_pkg.sv @@
// Shared types and constants for the vertex normal accumulator.
// No dependencies.
package vna_pkg;
  localparam int VertexCount = 4096;
  localparam int IndexBits = 12;
  localparam int PosBits = 16;
  localparam int SumBits = 40;
  localparam int FaceBits = 2 * PosBits + 3;
  localparam int NormBits = 16;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_TRI = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [IndexBits-1:0] vertex_index;
    logic signed [PosBits-1:0] pos_x;
    logic signed [PosBits-1:0] pos_y;
    logic signed [PosBits-1:0] pos_z;
    logic [IndexBits-1:0] corner_a;
    logic [IndexBits-1:0] corner_b;
    logic [IndexBits-1:0] corner_c;
  } item_t;

  typedef struct packed {
    logic signed [NormBits-1:0] normal_x;
    logic signed [NormBits-1:0] normal_y;
    logic signed [NormBits-1:0] normal_z;
    logic degenerate;
    logic overflowed;
  } result_t;

  typedef struct packed {
    logic signed [SumBits-1:0] x;
    logic signed [SumBits-1:0] y;
    logic signed [SumBits-1:0] z;
  } sum3_t;
endpackage

@@ design/vna_if.sv @@
// Valid/ready channel interfaces for the vertex normal accumulator.
// Depends on vna_pkg.
interface vna_item_if import vna_pkg::*; ();
  logic valid;
  logic ready;
  item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface vna_result_if import vna_pkg::*; ();
  logic valid;
  logic ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/vna_norm.sv @@
// Multicycle normalizer: scale, sum of squares, square root, three divisions.
// Depends on vna_pkg.
module vna_norm import vna_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input sum3_t sum,
  input logic mark,
  output logic done,
  output result_t res
);
  typedef enum logic [6:0] {
    N_IDLE = 7'b0000001, N_SCALE = 7'b0000010, N_SQ = 7'b0000100,
    N_SQRT = 7'b0001000, N_DIV = 7'b0010000, N_OUT = 7'b0100000,
    N_SHIFT = 7'b1000000
  } nstate_t;
  nstate_t state;
  logic [SumBits-1:0] mag [3];
  logic [2:0] neg;
  logic ovf;
  logic [5:0] blen;
  logic [5:0] blen_c;
  logic [30:0] u [3];
  logic [1:0] k;
  logic [63:0] q, rem, root;
  logic [5:0] step;
  logic [31:0] len;
  logic [45:0] dnum;
  logic [15:0] quo [3];
  logic [5:0] dstep;
  logic [46:0] drem;
  logic [SumBits-1:0] mmax;
  logic [63:0] trial;
  logic [62:0] sq;
  logic dbit;

  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
  end

  always_comb begin
    blen_c = 6'd0;
    for (int i = 0; i < SumBits; i++) begin
      if (mmax[i]) blen_c = 6'(i + 1);
    end
  end

  assign trial = (root << 2) | 64'd1;
  assign sq = 63'(u[k]) * 63'(u[k]);
  assign dbit = ({drem[45:0], dnum[45]} >= {15'd0, len});

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= N_IDLE;
    end else begin
      case (state)
        N_IDLE: begin
          if (start) begin
            mag[0] <= sum.x[SumBits-1] ? SumBits'(-sum.x) : sum.x;
            mag[1] <= sum.y[SumBits-1] ? SumBits'(-sum.y) : sum.y;
            mag[2] <= sum.z[SumBits-1] ? SumBits'(-sum.z) : sum.z;
            neg <= {sum.z[SumBits-1], sum.y[SumBits-1], sum.x[SumBits-1]};
            ovf <= mark;
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          blen <= blen_c;
          state <= N_SCALE;
        end
        N_SCALE: begin
          if (blen == 6'd0) begin
            res <= '{default: '0, degenerate: 1'b1, overflowed: ovf};
            done <= 1'b1;
            state <= N_IDLE;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (blen > 6'd31) u[i] <= 31'(mag[i] >> (blen - 6'd31));
              else u[i] <= 31'(mag[i] << (6'd31 - blen));
            end
            k <= 2'd0;
            q <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          q <= q + 64'(sq);
          if (k == 2'd2) begin
            rem <= q + 64'(sq);
            root <= '0;
            step <= 6'd32;
            state <= N_SQRT;
          end
          k <= k + 2'd1;
        end
        N_SQRT: begin
          if ((rem >> (2 * (step - 6'd1))) >= trial) begin
            rem <= rem - (trial << (2 * (step - 6'd1)));
            root <= (root << 1) | 64'd1;
          end else begin
            root <= root << 1;
          end
          step <= step - 6'd1;
          if (step == 6'd1) begin
            k <= 2'd0;
            state <= N_DIV;
            dstep <= 6'd0;
          end
        end
        N_DIV: begin
          if (dstep == 6'd0) begin
            len <= root[31:0];
            dnum <= 46'({u[k], 14'd0}) + 46'(root[31:1]);
            drem <= '0;
            dstep <= 6'd46;
          end else begin
            if (dbit) begin
              drem <= {drem[45:0], dnum[45]} - {15'd0, len};
            end else begin
              drem <= {drem[45:0], dnum[45]};
            end
            dnum <= {dnum[44:0], dbit};
            dstep <= dstep - 6'd1;
            if (dstep == 6'd1) begin
              quo[k] <= {dnum[14:0], dbit};
              if (k == 2'd2) state <= N_OUT;
              k <= k + 2'd1;
            end
          end
        end
        N_OUT: begin
          res.normal_x <= neg[0] ? -$signed(quo[0]) : $signed(quo[0]);
          res.normal_y <= neg[1] ? -$signed(quo[1]) : $signed(quo[1]);
          res.normal_z <= neg[2] ? -$signed(quo[2]) : $signed(quo[2]);
          res.degenerate <= 1'b0;
          res.overflowed <= ovf;
          done <= 1'b1;
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end
endmodule

@@ design/vertex_normal_accumulate.sv @@
// Top level of the vertex normal accumulator: position and sum memories,
// read-modify-write sequencer for loads and triangles, normalizer for reads.
// One item at a time: a load is written as it is accepted; a triangle updates each corner sum.
// A read gives its result after the square root and three bit-serial divides (skipped
// for a zero sum) of the normalizer; it waits while a result is held.
// Synchronous reset clears control state only; memories are undefined until written.
module vertex_normal_accumulate import vna_pkg::*; (
  input logic clk,
  input logic rst,
  vna_item_if.sink in_ch,
  vna_result_if.source out_ch
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_PRD = 7'b0000010, S_DIFF = 7'b0000100,
    S_MUL = 7'b0001000, S_SRD = 7'b0010000, S_SWR = 7'b0100000,
    S_NORM = 7'b1000000
  } state_t;
  state_t state;
  item_t item;
  logic [3*PosBits-1:0] pos_mem [VertexCount];
  logic [3*SumBits:0] sum_mem [VertexCount];
  logic [3*PosBits-1:0] pos_rd;
  logic [3*SumBits:0] sum_rd;
  logic [IndexBits-1:0] paddr, saddr;
  logic [1:0] cnt;
  logic signed [PosBits-1:0] pa [3], pb [3], pc [3];
  logic signed [PosBits:0] ab [3], ac [3];
  logic signed [2*PosBits+1:0] pr [6];
  logic signed [FaceBits-1:0] face [3];
  logic norm_start, norm_done;
  result_t norm_res;
  sum3_t norm_sum;
  logic norm_mark, out_valid;
  result_t out_data;
  logic signed [SumBits:0] t [3];
  logic signed [SumBits-1:0] ns [3];
  logic nmark;

  always_comb begin
    case (cnt)
      2'd0: paddr = item.corner_a;
      2'd1: paddr = item.corner_b;
      default: paddr = item.corner_c;
    endcase
  end

  always_ff @(posedge clk) begin
    pos_rd <= pos_mem[paddr];
    sum_rd <= sum_mem[saddr];
    if (in_ch.valid && in_ch.ready && in_ch.data.operation == OP_LOAD) begin
      pos_mem[in_ch.data.vertex_index] <=
        {in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.pos_z};
    end
  end

  always_comb begin
    nmark = sum_rd[3*SumBits];
    for (int i = 0; i < 3; i++) begin
      t[i] = (SumBits+1)'($signed(sum_rd[(2-i)*SumBits +: SumBits]))
           + (SumBits+1)'(face[i]);
      if (t[i][SumBits] != t[i][SumBits-1]) begin
        nmark = 1'b1;
        ns[i] = t[i][SumBits] ? {1'b1, {(SumBits-1){1'b0}}}
                              : {1'b0, {(SumBits-1){1'b1}}};
      end else begin
        ns[i] = t[i][SumBits-1:0];
      end
    end
  end

  assign in_ch.ready = (state == S_IDLE);
  assign norm_sum = '{x: sum_rd[3*SumBits-1 -: SumBits],
                      y: sum_rd[2*SumBits-1 -: SumBits], z: sum_rd[SumBits-1:0]};
  assign norm_mark = sum_rd[3*SumBits];

  always_ff @(posedge clk) begin
    norm_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item <= in_ch.data;
            cnt <= 2'd0;
            saddr <= in_ch.data.vertex_index;
            case (op_t'(in_ch.data.operation))
              OP_LOAD: sum_mem[in_ch.data.vertex_index] <= '0;
              OP_TRI: state <= S_PRD;
              OP_READ: state <= S_SRD;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_PRD: begin
          cnt <= cnt + 2'd1;
          for (int i = 0; i < 3; i++) begin
            if (cnt == 2'd1) pa[i] <= pos_rd[(2-i)*PosBits +: PosBits];
            if (cnt == 2'd2) pb[i] <= pos_rd[(2-i)*PosBits +: PosBits];
            if (cnt == 2'd3) pc[i] <= pos_rd[(2-i)*PosBits +: PosBits];
          end
          if (cnt == 2'd3) state <= S_DIFF;
        end
        S_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            ab[i] <= (PosBits+1)'(pa[i]) - (PosBits+1)'(pb[i]);
            ac[i] <= (PosBits+1)'(pa[i]) - (PosBits+1)'(pc[i]);
          end
          state <= S_MUL;
          cnt <= 2'd0;
        end
        S_MUL: begin
          if (cnt == 2'd0) begin
            pr[0] <= ac[1] * ab[2]; pr[1] <= ac[2] * ab[1];
            pr[2] <= ac[2] * ab[0]; pr[3] <= ac[0] * ab[2];
            pr[4] <= ac[0] * ab[1]; pr[5] <= ac[1] * ab[0];
            cnt <= 2'd1;
          end else begin
            face[0] <= FaceBits'(pr[0]) - FaceBits'(pr[1]);
            face[1] <= FaceBits'(pr[2]) - FaceBits'(pr[3]);
            face[2] <= FaceBits'(pr[4]) - FaceBits'(pr[5]);
            cnt <= 2'd0;
            saddr <= item.corner_a;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (item.operation != OP_READ) begin
            state <= S_SWR;
          end else if (!out_valid) begin
            norm_start <= 1'b1;
            state <= S_NORM;
          end
        end
        S_SWR: begin
          sum_mem[saddr] <= {nmark, ns[0], ns[1], ns[2]};
          cnt <= cnt + 2'd1;
          saddr <= (cnt == 2'd0) ? item.corner_b : item.corner_c;
          state <= (cnt == 2'd2) ? S_IDLE : S_SRD;
        end
        S_NORM: begin
          if (norm_done) begin
            out_data <= norm_res;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  vna_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_start), .sum(norm_sum),
    .mark(norm_mark), .done(norm_done), .res(norm_res)
  );

  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;
endmodule

@@ verif/vertex_normal_accumulate_tb.sv @@
// Testbench for vertex_normal_accumulate: loads, triangles and reads with a
// bit-accurate predictor of the sums and the normalized Q1.14 read results.
// Depends on vna_pkg, vna_if and the vertex_normal_accumulate top level.
module vertex_normal_accumulate_tb;
  import vna_pkg::*;

  localparam longint SumMax = 64'sd549755813887;
  localparam longint SumMin = -SumMax - 1;

  logic clk;
  logic rst;
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  vna_item_if in_ch ();
  vna_result_if out_ch ();

  vertex_normal_accumulate uut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  // Mirror of the block's memories.
  longint pos_mem[VertexCount][3];
  longint sum_mem[VertexCount][3];
  bit sat_mark[VertexCount];
  bit is_loaded[VertexCount];
  int loaded_list[$];
  result_t pending_normals[$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sat_add(longint s, longint n, inout bit mark);
    longint r;
    r = s + n;
    if (r > SumMax) begin
      mark = 1'b1;
      return SumMax;
    end
    if (r < SumMin) begin
      mark = 1'b1;
      return SumMin;
    end
    return r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t normal_of(int idx);
    result_t r;
    longint unsigned u[3];
    longint unsigned m;
    longint unsigned q;
    longint unsigned len;
    longint unsigned c;
    int nb;
    r = '0;
    m = 0;
    q = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = (sum_mem[idx][i] < 0) ? longint'(-sum_mem[idx][i]) : sum_mem[idx][i];
      if (u[i] > m) m = u[i];
    end
    r.overflowed = sat_mark[idx];
    if (m == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    nb = 0;
    while (m != 0) begin
      nb++;
      m = m >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (nb > 31) u[i] = u[i] >> (nb - 31);
      else u[i] = u[i] << (31 - nb);
      q += u[i] * u[i];
    end
    len = int_sqrt(q);
    for (int i = 0; i < 3; i++) begin
      c = (u[i] * 16384 + len / 2) / len;
      if (sum_mem[idx][i] < 0) c = -c;
      if (i == 0) r.normal_x = c[15:0];
      else if (i == 1) r.normal_y = c[15:0];
      else r.normal_z = c[15:0];
    end
    return r;
  endfunction

  task automatic apply_item(item_t it);
    longint ab[3];
    longint ac[3];
    longint n[3];
    int cn[3];
    case (op_t'(it.operation))
      OP_LOAD: begin
        pos_mem[it.vertex_index][0] = it.pos_x;
        pos_mem[it.vertex_index][1] = it.pos_y;
        pos_mem[it.vertex_index][2] = it.pos_z;
        for (int k = 0; k < 3; k++) sum_mem[it.vertex_index][k] = 0;
        sat_mark[it.vertex_index] = 1'b0;
      end
      OP_TRI: begin
        cn[0] = it.corner_a;
        cn[1] = it.corner_b;
        cn[2] = it.corner_c;
        for (int k = 0; k < 3; k++) begin
          ab[k] = pos_mem[cn[0]][k] - pos_mem[cn[1]][k];
          ac[k] = pos_mem[cn[0]][k] - pos_mem[cn[2]][k];
        end
        n[0] = ac[1] * ab[2] - ac[2] * ab[1];
        n[1] = ac[2] * ab[0] - ac[0] * ab[2];
        n[2] = ac[0] * ab[1] - ac[1] * ab[0];
        for (int v = 0; v < 3; v++)
          for (int k = 0; k < 3; k++)
            sum_mem[cn[v]][k] = sat_add(sum_mem[cn[v]][k], n[k], sat_mark[cn[v]]);
      end
      OP_READ: pending_normals = {pending_normals, normal_of(it.vertex_index)};
      default: ;
    endcase
  endtask

  task automatic send_item(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    apply_item(it);
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic item_t noise_item();
    item_t it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(item_t)-1:0];
    it.operation = OP_NONE;
    return it;
  endfunction

  function automatic item_t load_item(int idx, int x, int y, int z);
    item_t it;
    it = noise_item();
    it.operation = OP_LOAD;
    it.vertex_index = IndexBits'(idx);
    it.pos_x = PosBits'(x);
    it.pos_y = PosBits'(y);
    it.pos_z = PosBits'(z);
    return it;
  endfunction

  function automatic item_t tri_item(int a, int b, int c);
    item_t it;
    it = noise_item();
    it.operation = OP_TRI;
    it.corner_a = IndexBits'(a);
    it.corner_b = IndexBits'(b);
    it.corner_c = IndexBits'(c);
    return it;
  endfunction

  function automatic item_t read_item(int idx);
    item_t it;
    it = noise_item();
    it.operation = OP_READ;
    it.vertex_index = IndexBits'(idx);
    return it;
  endfunction

  task automatic send_load(int idx, int x, int y, int z);
    send_item(load_item(idx, x, y, z));
    if (!is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_list = {loaded_list, idx};
    end
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Long receiver hold-off, counted down once per cycle.
  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Result checker and receiver stall control.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_normals.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_ch.data);
          errors++;
        end else begin
          want = pending_normals.pop_front();
          if (out_ch.data.normal_x !== want.normal_x) begin
            $display("%0t: normal_x expected %0d actual %0d", $time,
                     want.normal_x, out_ch.data.normal_x);
            errors++;
          end
          if (out_ch.data.normal_y !== want.normal_y) begin
            $display("%0t: normal_y expected %0d actual %0d", $time,
                     want.normal_y, out_ch.data.normal_y);
            errors++;
          end
          if (out_ch.data.normal_z !== want.normal_z) begin
            $display("%0t: normal_z expected %0d actual %0d", $time,
                     want.normal_z, out_ch.data.normal_z);
            errors++;
          end
          if (out_ch.data.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b actual %0b", $time,
                     want.degenerate, out_ch.data.degenerate);
            errors++;
          end
          if (out_ch.data.overflowed !== want.overflowed) begin
            $display("%0t: overflowed expected %0b actual %0b", $time,
                     want.overflowed, out_ch.data.overflowed);
            errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic test_directed();
    send_load(0, 0, 0, 0);
    send_load(4095, 32767, 32767, 32767);
    send_load(2, -32768, -32768, -32768);
    send_load(1, 256, 0, 0);
    send_load(5, 0, 256, 0);
    send_load(6, 0, 0, 256);
    send_item(read_item(0));
    send_item(tri_item(0, 1, 5));
    send_item(tri_item(0, 5, 6));
    send_item(tri_item(0, 4095, 2));
    send_item(tri_item(1, 1, 6));
    send_item(tri_item(4095, 4095, 4095));
    send_item(noise_item());
    send_item(read_item(0));
    send_item(read_item(1));
    send_item(read_item(5));
    send_item(read_item(6));
    send_item(read_item(4095));
    send_item(read_item(2));
    send_load(0, 0, 0, 0);
    send_item(read_item(0));
    wait_drained();
  endtask

  task automatic test_saturation();
    send_load(100, -32768, -32768, 32767);
    send_load(101, 32767, -32768, -32768);
    send_load(102, -32768, 32767, -32768);
    for (int i = 0; i < 140; i++) send_item(tri_item(100, 101, 102));
    send_item(read_item(100));
    send_load(200, -32768, -32768, 32767);
    send_load(201, 32767, -32768, -32768);
    send_load(202, -32768, 32767, -32768);
    for (int i = 0; i < 140; i++) send_item(tri_item(200, 202, 201));
    send_item(read_item(201));
    send_item(read_item(202));
    wait_drained();
  endtask

  function automatic int rand_pos();
    if ($urandom_range(1)) return $urandom_range(65535) - 32768;
    return $urandom_range(1023) - 512;
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  task automatic send_random(int count);
    int roll;
    int a;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 12) begin
        a = ($urandom_range(3) == 0) ? $urandom_range(VertexCount - 1) : pick_loaded();
        send_load(a, rand_pos(), rand_pos(), rand_pos());
      end else if (roll < 60) begin
        a = pick_loaded();
        if ($urandom_range(9) == 0)
          send_item(tri_item(a, a, pick_loaded()));
        else
          send_item(tri_item(a, pick_loaded(), pick_loaded()));
      end else if (roll < 95) begin
        send_item(read_item(pick_loaded()));
      end else begin
        send_item(noise_item());
      end
    end
  endtask

  task automatic test_random(int count, int idle, int stall);
    idle_pct = idle;
    stall_pct = stall;
    send_random(count);
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 1500;
    for (int i = 0; i < 40; i++) send_item(read_item(pick_loaded()));
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_saturation();
    for (int i = 0; i < 24; i++)
      send_load($urandom_range(VertexCount - 1), rand_pos(), rand_pos(), rand_pos());
    test_random(250, 0, 0);
    test_random(250, 51, 0);
    test_random(250, 0, 51);
    test_random(250, 32, 32);
    test_backpressure();
    if (errors == 0 && pending_normals.size() == 0) begin
      $display("vertex_normal_accumulate_tb passed");
    end else begin
      $display("vertex_normal_accumulate_tb failed");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("vertex_normal_accumulate_tb failed");
    $finish;
  end
endmodule

@@ files.f @@
design/vna_pkg.sv
design/vna_if.sv
design/vna_norm.sv
design/vertex_normal_accumulate.sv
verif/vertex_normal_accumulate_tb.sv
